/* rtl/b2d_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b2d_pkg: shared types and constants of the binary128 to decimal converter
// Holds the datapath sizes, the micro-operation codes, the jump conditions
// and the control program of the sequencer.
// ----------------------------------------------------------------------------
package b2d_pkg;

  // Width of the binary value and the number of decimal digits that it needs.
  localparam int unsigned VALUE_W    = 128;
  localparam int unsigned NUM_DIGITS = 39;
  localparam int unsigned BCD_W      = 4 * NUM_DIGITS;
  localparam int unsigned BIT_CNT_W  = $clog2(VALUE_W);
  localparam int unsigned CNT_W      = $clog2(NUM_DIGITS + 1);
  localparam int unsigned PC_W       = 2;

  // Micro-operations that the datapath carries out.
  typedef enum logic [2:0] {
    OP_LOAD   = 3'd0,
    OP_DABBLE = 3'd1,
    OP_SCAN   = 3'd2,
    OP_EMIT   = 3'd3
  } op_e;

  // Conditions under which the sequencer takes the jump of a step.
  typedef enum logic [1:0] {
    C_IDLE      = 2'd0,
    C_BITS_LEFT = 2'd1,
    C_SKIP      = 2'd2,
    C_MORE      = 2'd3
  } cond_e;

  // One control word of the program.
  typedef struct packed {
    op_e              op;
    cond_e            cond;
    logic [PC_W-1:0]  target;
    logic             busy;
  } ctrl_word_t;

  // Command from the sequencer to the datapath.
  typedef struct packed {
    op_e  op;
    logic en;
  } dp_ctrl_t;

  // Status from the datapath to the sequencer.
  typedef struct packed {
    logic bits_left;
    logic skip;
    logic more;
  } dp_status_t;

  // Step addresses of the program.
  localparam logic [PC_W-1:0] PC_IDLE   = 2'd0;
  localparam logic [PC_W-1:0] PC_DABBLE = 2'd1;
  localparam logic [PC_W-1:0] PC_SCAN   = 2'd2;
  localparam logic [PC_W-1:0] PC_EMIT   = 2'd3;

  // Control program. A step jumps to its target while its condition holds,
  // otherwise it falls through to the next step; the last step wraps to idle.
  function automatic ctrl_word_t rom_word(logic [PC_W-1:0] pc);
    ctrl_word_t w;
    unique case (pc)
      PC_IDLE:   w = '{op: OP_LOAD,   cond: C_IDLE,      target: PC_IDLE,   busy: 1'b0};
      PC_DABBLE: w = '{op: OP_DABBLE, cond: C_BITS_LEFT, target: PC_DABBLE, busy: 1'b1};
      PC_SCAN:   w = '{op: OP_SCAN,   cond: C_SKIP,      target: PC_SCAN,   busy: 1'b1};
      default:   w = '{op: OP_EMIT,   cond: C_MORE,      target: PC_EMIT,   busy: 1'b1};
    endcase
    return w;
  endfunction

endpackage

/* rtl/b2d_datapath.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b2d_datapath: shift-add-3 converter and digit shifter
// Holds the binary shift register and the packed BCD digits, carries out one
// micro-operation per cycle and registers the emitted digit.
// ----------------------------------------------------------------------------
module b2d_datapath import b2d_pkg::*; #(
  parameter int unsigned MAX_DIGITS = 39
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  dp_ctrl_t            ctrl_i,
  input  logic [63:0]         value_low_i,
  input  logic [63:0]         value_high_i,
  output dp_status_t          status_o,
  output logic                digit_valid_o,
  output logic [5:0]          digit_char_o,
  output logic                last_digit_o
);

  localparam logic [CNT_W-1:0]     MaxCnt  = CNT_W'(MAX_DIGITS);
  localparam logic [CNT_W-1:0]     OneCnt  = CNT_W'(1);
  localparam logic [CNT_W-1:0]     FullCnt = CNT_W'(NUM_DIGITS);
  localparam logic [BIT_CNT_W-1:0] LastBit = BIT_CNT_W'(VALUE_W - 1);
  localparam logic [5:0]           AsciiZero = 6'd48;

  logic [VALUE_W-1:0]   bin_q, bin_d;
  logic [BCD_W-1:0]     bcd_q, bcd_d;
  logic [BCD_W-1:0]     adj;
  logic [BIT_CNT_W-1:0] bit_cnt_q, bit_cnt_d;
  logic [CNT_W-1:0]     cnt_q, cnt_d;
  logic                 seen_q, seen_d;
  logic                 valid_q, valid_d;
  logic [5:0]           char_q, char_d;
  logic                 last_q, last_d;
  logic [3:0]           top;

  // The digit at the top of the BCD register is the next one to look at.
  assign top = bcd_q[BCD_W-1 -: 4];

  // Add three to every digit of five or more before the shift.
  always_comb begin
    for (int i = 0; i < NUM_DIGITS; i++) begin
      adj[4*i +: 4] = (bcd_q[4*i +: 4] >= 4'd5) ? bcd_q[4*i +: 4] + 4'd3 : bcd_q[4*i +: 4];
    end
  end

  // Status for the sequencer's jumps.
  always_comb begin
    status_o.bits_left = (bit_cnt_q != LastBit);
    status_o.more      = (cnt_q != OneCnt);
    // Digits above the kept range always go; leading zeros go until one remains.
    status_o.skip      = (cnt_q > MaxCnt) ||
                         (!seen_q && (top == 4'd0) && (cnt_q != OneCnt));
  end

  // Next-state logic of the datapath, one micro-operation per cycle.
  always_comb begin
    bin_d     = bin_q;
    bcd_d     = bcd_q;
    bit_cnt_d = bit_cnt_q;
    cnt_d     = cnt_q;
    seen_d    = seen_q;
    valid_d   = 1'b0;
    char_d    = char_q;
    last_d    = last_q;
    unique case (ctrl_i.op)
      OP_LOAD: begin
        if (ctrl_i.en) begin
          bin_d     = {value_high_i, value_low_i};
          bcd_d     = '0;
          bit_cnt_d = '0;
          cnt_d     = FullCnt;
          seen_d    = 1'b0;
        end
      end
      OP_DABBLE: begin
        bcd_d     = {adj[BCD_W-2:0], bin_q[VALUE_W-1]};
        bin_d     = {bin_q[VALUE_W-2:0], 1'b0};
        bit_cnt_d = bit_cnt_q + 1'b1;
      end
      OP_SCAN: begin
        if (status_o.skip) begin
          bcd_d  = {bcd_q[BCD_W-5:0], 4'd0};
          cnt_d  = cnt_q - 1'b1;
          seen_d = seen_q | (top != 4'd0);
        end
      end
      OP_EMIT: begin
        valid_d = 1'b1;
        char_d  = AsciiZero | {2'b00, top};
        last_d  = (cnt_q == OneCnt);
        bcd_d   = {bcd_q[BCD_W-5:0], 4'd0};
        cnt_d   = cnt_q - 1'b1;
      end
      default: begin
        valid_d = 1'b0;
      end
    endcase
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    bin_q  <= bin_d;
    bcd_q  <= bcd_d;
    char_q <= char_d;
    last_q <= last_d;
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bit_cnt_q <= '0;
      cnt_q     <= '0;
      seen_q    <= 1'b0;
      valid_q   <= 1'b0;
    end else begin
      bit_cnt_q <= bit_cnt_d;
      cnt_q     <= cnt_d;
      seen_q    <= seen_d;
      valid_q   <= valid_d;
    end
  end

  assign digit_valid_o = valid_q;
  assign digit_char_o  = char_q;
  assign last_digit_o  = last_q;

endmodule

/* rtl/binary128_to_decimal_ascii.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// binary128_to_decimal_ascii: unsigned 128-bit value to ASCII decimal digits
// Microcoded shift-add-3 converter that, once the conversion is done, emits one digit word per cycle.
// ----------------------------------------------------------------------------
// A word is taken when start_i is high and busy_o is low. The block then runs
// 128 shift-add-3 steps, strips leading zero digits one per cycle, and puts
// the digits on digit_char_o most significant first, one per cycle, each for
// exactly one cycle with digit_valid_o high; last_digit_o marks the final one.
// A zero value gives the single digit '0'. Values with more than MAX_DIGITS
// digits give only their MAX_DIGITS low digits. The receiver cannot stall the
// output. After the idle cycle in which a word is taken, busy_o stays high
// through the 128 conversion steps, the zero scan and the digit emission.
// The last digit appears in the cycle in which busy_o falls, so a new word
// may start right then.
module binary128_to_decimal_ascii import b2d_pkg::*; #(
  parameter int unsigned MAX_DIGITS = 39
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic [63:0] value_low_i,
  input  logic [63:0] value_high_i,
  output logic        digit_valid_o,
  output logic [5:0]  digit_char_o,
  output logic        last_digit_o
);

  logic [PC_W-1:0] pc_q, pc_d;
  ctrl_word_t      cw;
  dp_ctrl_t        dp_ctrl;
  dp_status_t      dp_status;
  logic            cond_true;
  logic            accept;

  // Fetch the control word of the current step.
  assign cw     = rom_word(pc_q);
  assign busy_o = cw.busy;
  assign accept = start_i && !busy_o;

  // Evaluate the jump condition of the step.
  always_comb begin
    unique case (cw.cond)
      C_IDLE:      cond_true = !start_i;
      C_BITS_LEFT: cond_true = dp_status.bits_left;
      C_SKIP:      cond_true = dp_status.skip;
      C_MORE:      cond_true = dp_status.more;
      default:     cond_true = 1'b0;
    endcase
  end

  // Jump while the condition holds, otherwise fall through to the next step.
  assign pc_d = cond_true ? cw.target : pc_q + 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q <= PC_IDLE;
    end else begin
      pc_q <= pc_d;
    end
  end

  // Command to the datapath; a load only happens on an accepted word.
  assign dp_ctrl.op = cw.op;
  assign dp_ctrl.en = accept;

  b2d_datapath #(
    .MAX_DIGITS(MAX_DIGITS)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .ctrl_i        (dp_ctrl),
    .value_low_i   (value_low_i),
    .value_high_i  (value_high_i),
    .status_o      (dp_status),
    .digit_valid_o (digit_valid_o),
    .digit_char_o  (digit_char_o),
    .last_digit_o  (last_digit_o)
  );

`ifndef ASSERT_OFF
  // An accepted word always starts the conversion program.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (busy_o && (pc_q == PC_DABBLE)))
    else $error("accepted word did not start conversion");

  // Digits only come out of the emit step.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    digit_valid_o |-> ($past(pc_q) == PC_EMIT))
    else $error("digit strobe outside the emit step");

  // Every emitted character is an ASCII decimal digit.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    digit_valid_o |-> (digit_char_o >= 6'd48) && (digit_char_o <= 6'd57))
    else $error("emitted character is not a decimal digit");

  // The last digit of a run comes as the sequencer returns to idle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (digit_valid_o && last_digit_o) |-> !busy_o)
    else $error("last digit while still busy");

  // No digit follows the last one in the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (digit_valid_o && last_digit_o) |=> !digit_valid_o)
    else $error("digit after the end of a run");
`endif

endmodule
